FILE: src/nsf_pkg.sv
// Shared widths, table entry type and tdata layout for the nearest sensor fill block.
package nsf_pkg;

   // Table geometry and field widths
   localparam int MAX_SENSORS = 64;
   localparam int SLOT_BITS   = $clog2(MAX_SENSORS);
   localparam int COUNT_BITS  = $clog2(MAX_SENSORS + 1);
   localparam int COORD_BITS  = 8;
   localparam int VALUE_BITS  = 32;
   localparam int SQ_BITS     = 2 * COORD_BITS;
   localparam int DIST_BITS   = SQ_BITS + 1;

   // Stream packing: fields from the lowest bit up, padded to whole bytes
   localparam int REQ_FIELD_BITS = SLOT_BITS + 2 * COORD_BITS + VALUE_BITS;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = VALUE_BITS + SLOT_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   // Input command codes carried on req_tuser
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // One sensor slot as held in the table
   typedef struct packed {
      logic [VALUE_BITS-1:0] sample;
      logic [COORD_BITS-1:0] row;
      logic [COORD_BITS-1:0] col;
   } sensor_entry_type;

endpackage

FILE: src/nsf_sensor_mem.sv
// Sensor table: one write port, one read port with registered read data.
module nsf_sensor_mem (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [nsf_pkg::SLOT_BITS-1:0]     wr_addr,
   input  nsf_pkg::sensor_entry_type         wr_data,
   input  logic                              rd_en,
   input  logic [nsf_pkg::SLOT_BITS-1:0]     rd_addr,
   output nsf_pkg::sensor_entry_type         rd_data
);

   nsf_pkg::sensor_entry_type mem_ff [nsf_pkg::MAX_SENSORS];
   nsf_pkg::sensor_entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/nearest_sensor_fill_core.sv
// Top level of the nearest sensor fill block: handshakes, scan sequencer and result register.
//
// Usage:
//   req_* carries load and query transactions (req_tuser selects which).
//   A load writes one sensor slot and gives no result.
//   A query scans slots 0 .. sensor_count-1 (saturated at the table size)
//   one slot per cycle through the table's read port and returns one
//   transaction on rsp_*: the nearest slot by squared distance, skipping a
//   slot on the pixel itself, the later slot winning a tie.
//   A query moves from the scan (skipped with no slot in use) to a flush that
//   drains the read and distance stages, then to a state that loads the result;
//   the read port of the sensor table sets the one-slot-per-cycle pace.
//   A load leaves the block idle, ready for the next transaction.
//   Only one query is in flight; req_tready is low from its acceptance until
//   its result enters the output register.
//   The result sits in an output register, so the next transaction is
//   accepted while it waits; a stalled receiver holds up only the end of
//   the following query.
//   csr_* writes sensor_count; it is to be written only while the block is idle (not enforced here).
//   Reset clears sensor_count and all control state; table contents are
//   undefined until loaded.
module nearest_sensor_fill_core (
   input  logic                                 clock,
   input  logic                                 reset,
   // configuration
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [nsf_pkg::COUNT_BITS-1:0]       csr_data,
   // request stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [nsf_pkg::REQ_DATA_BITS-1:0]    req_tdata,  // slot_index, pos_x, pos_y, sample_value
   input  logic [0:0]                           req_tuser,  // cmd
   // response stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [nsf_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,  // fill_value, source_slot
   output logic [0:0]                           rsp_tuser   // found
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   localparam int CB = nsf_pkg::COUNT_BITS;
   localparam int SB = nsf_pkg::SLOT_BITS;
   localparam int XB = nsf_pkg::COORD_BITS;
   localparam int VB = nsf_pkg::VALUE_BITS;
   localparam int DB = nsf_pkg::DIST_BITS;
   localparam int QB = nsf_pkg::SQ_BITS;

   // request field unpacking
   logic          req_cmd;
   logic [SB-1:0] req_slot;
   logic [XB-1:0] req_x;
   logic [XB-1:0] req_y;
   logic [VB-1:0] req_sample;

   assign req_cmd    = req_tuser[0];
   assign req_slot   = req_tdata[SB-1:0];
   assign req_x      = req_tdata[SB+XB-1:SB];
   assign req_y      = req_tdata[SB+2*XB-1:SB+XB];
   assign req_sample = req_tdata[SB+2*XB+VB-1:SB+2*XB];

   logic [1:0]    state_ff,    state_in;
   logic [CB-1:0] count_ff;
   logic [CB-1:0] n_ff,        n_in;
   logic [CB-1:0] scan_cnt_ff, scan_cnt_in;
   logic [XB-1:0] qx_ff;
   logic [XB-1:0] qy_ff;
   logic [CB-1:0] count_eff;
   logic          req_acc;
   logic          rd_vld_ff;
   logic          dist_vld_ff;
   logic          rsp_vld_ff;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign count_eff  = (count_ff > CB'(nsf_pkg::MAX_SENSORS)) ?
                       CB'(nsf_pkg::MAX_SENSORS) : count_ff;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         count_ff <= csr_data;
      end
   end

   // sensor table
   nsf_pkg::sensor_entry_type wr_entry;
   nsf_pkg::sensor_entry_type rd_entry;
   logic                      mem_wr_en;
   logic                      mem_rd_en;

   assign wr_entry.col    = req_x;
   assign wr_entry.row    = req_y;
   assign wr_entry.sample = req_sample;
   assign mem_wr_en       = req_acc && (req_cmd == nsf_pkg::CMD_LOAD);
   assign mem_rd_en       = (state_ff == ST_SCAN);

   nsf_sensor_mem u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (req_slot),
      .wr_data (wr_entry),
      .rd_en   (mem_rd_en),
      .rd_addr (scan_cnt_ff[SB-1:0]),
      .rd_data (rd_entry)
   );

   // sequencer
   logic load_rsp;

   always_comb begin
      state_in    = state_ff;
      n_in        = n_ff;
      scan_cnt_in = scan_cnt_ff;
      load_rsp    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_cmd == nsf_pkg::CMD_QUERY)) begin
               n_in        = count_eff;
               scan_cnt_in = '0;
               state_in    = (count_eff == '0) ? ST_FLUSH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            scan_cnt_in = scan_cnt_ff + CB'(1);
            if (scan_cnt_in == n_ff) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!rd_vld_ff && !dist_vld_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_vld_ff || rsp_tready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         n_ff        <= '0;
         scan_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         n_ff        <= n_in;
         scan_cnt_ff <= scan_cnt_in;
      end
   end

   // query pixel capture
   always_ff @(posedge clock) begin
      if (req_acc && (req_cmd == nsf_pkg::CMD_QUERY)) begin
         qx_ff <= req_x;
         qy_ff <= req_y;
      end
   end

   // stage 1: read data valid tracking
   logic [SB-1:0] rd_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= mem_rd_en;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= scan_cnt_ff[SB-1:0];
   end

   // stage 2: squared distance of the slot just read
   logic [XB-1:0] dx;
   logic [XB-1:0] dy;
   logic [QB-1:0] sq_x;
   logic [QB-1:0] sq_y;
   logic [DB-1:0] dist_in;
   logic          skip_in;

   assign dx      = (rd_entry.col >= qx_ff) ? (rd_entry.col - qx_ff) : (qx_ff - rd_entry.col);
   assign dy      = (rd_entry.row >= qy_ff) ? (rd_entry.row - qy_ff) : (qy_ff - rd_entry.row);
   assign sq_x    = QB'(dx) * QB'(dx);
   assign sq_y    = QB'(dy) * QB'(dy);
   assign dist_in = DB'(sq_x) + DB'(sq_y);
   assign skip_in = (rd_entry.col == qx_ff) && (rd_entry.row == qy_ff);

   logic [DB-1:0] dist_ff;
   logic          skip_ff;
   logic [SB-1:0] dist_idx_ff;
   logic [VB-1:0] dist_smp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_vld_ff <= 1'b0;
      end else begin
         dist_vld_ff <= rd_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      dist_ff     <= dist_in;
      skip_ff     <= skip_in;
      dist_idx_ff <= rd_idx_ff;
      dist_smp_ff <= rd_entry.sample;
   end

   // stage 3: running best, later slot wins a tie
   logic          have_ff;
   logic [DB-1:0] best_dist_ff;
   logic [SB-1:0] best_slot_ff;
   logic [VB-1:0] best_smp_ff;
   logic          take_best;

   assign take_best = dist_vld_ff && !skip_ff && (!have_ff || (dist_ff <= best_dist_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
      end else if (req_acc && (req_cmd == nsf_pkg::CMD_QUERY)) begin
         have_ff <= 1'b0;
      end else if (take_best) begin
         have_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take_best) begin
         best_dist_ff <= dist_ff;
         best_slot_ff <= dist_idx_ff;
         best_smp_ff  <= dist_smp_ff;
      end
   end

   // output register
   logic [VB-1:0] rsp_value_ff;
   logic [SB-1:0] rsp_slot_ff;
   logic          rsp_found_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= load_rsp || (rsp_vld_ff && !rsp_tready);
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_value_ff <= have_ff ? best_smp_ff  : '0;
         rsp_slot_ff  <= have_ff ? best_slot_ff : '0;
         rsp_found_ff <= have_ff;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {(nsf_pkg::RSP_DATA_BITS - nsf_pkg::RSP_FIELD_BITS)'(0),
                        rsp_slot_ff, rsp_value_ff};
   assign rsp_tuser  = rsp_found_ff;

   // checks
   a_ready_pipe_empty : assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (!rd_vld_ff && !dist_vld_ff))
      else $error("request accepted while scan pipeline busy");

   a_scan_in_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_cnt_ff < n_ff))
      else $error("scan address beyond slots in use");

   a_rsp_from_done : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("response raised outside completion");

   a_best_in_range : assert property (@(posedge clock) disable iff (reset)
      ((state_ff != ST_IDLE) && have_ff) |-> ({1'b0, best_slot_ff} < n_ff))
      else $error("best slot outside slots in use");

endmodule
